// File: hw/rtl/smav_pkg.sv
package smav_pkg;

  localparam int MAX_WINDOW     = 128;
  localparam int SAMPLE_BITS    = 20;
  localparam int WLEN_BITS      = 8;
  localparam int ADDR_BITS      = $clog2(MAX_WINDOW);
  localparam int FILL_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS       = SAMPLE_BITS + ADDR_BITS;
  localparam int DIV_CNT_BITS   = $clog2(SUM_BITS + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam int PADDR_BITS     = 3;
  localparam int PDATA_BITS     = 32;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RESET = WLEN_BITS'(4);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first;
    logic                   pass;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// File: hw/rtl/smav_ram.sv
module smav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/smav_div.sv
module smav_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smav_pkg::SUM_BITS-1:0]  dividend,
  input  logic [smav_pkg::FILL_BITS-1:0] divisor,
  output logic                          busy,
  output logic                          done,
  output logic [smav_pkg::SUM_BITS-1:0]  quotient
);

  logic [smav_pkg::FILL_BITS-1:0]    rem;
  logic [smav_pkg::FILL_BITS-1:0]    dvs;
  logic [smav_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [smav_pkg::FILL_BITS:0]      trial;
  logic [smav_pkg::FILL_BITS:0]      diff;
  logic                              ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quotient[smav_pkg::SUM_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == smav_pkg::DIV_CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= smav_pkg::DIV_CNT_BITS'(smav_pkg::SUM_BITS);
    end else if (busy) begin
      quotient <= {quotient[smav_pkg::SUM_BITS-2:0], ge};
      rem      <= ge ? diff[smav_pkg::FILL_BITS-1:0] : trial[smav_pkg::FILL_BITS-1:0];
      cnt      <= cnt - smav_pkg::DIV_CNT_BITS'(1);
    end
  end

endmodule

// File: hw/rtl/smav_front.sv
module smav_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [smav_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                          first,
  input  logic [smav_pkg::FILL_BITS-1:0] k,
  output logic                          item_valid,
  output smav_pkg::item_t               item,
  input  logic                          item_take
);

  smav_pkg::item_t                     slots [smav_pkg::QUEUE_DEPTH];
  logic [smav_pkg::QUEUE_PTR_BITS-1:0] head;
  logic [smav_pkg::QUEUE_PTR_BITS-1:0] tail;
  logic [smav_pkg::QUEUE_PTR_BITS:0]   count;
  logic                                wr;
  logic                                rd;

  assign full       = count == (smav_pkg::QUEUE_PTR_BITS + 1)'(smav_pkg::QUEUE_DEPTH);
  assign item_valid = count != '0;
  assign item       = slots[head];
  assign wr         = push && !full;
  assign rd         = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= tail + smav_pkg::QUEUE_PTR_BITS'(1);
      end
      if (rd) begin
        head <= head + smav_pkg::QUEUE_PTR_BITS'(1);
      end
      if (wr && !rd) begin
        count <= count + (smav_pkg::QUEUE_PTR_BITS + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (smav_pkg::QUEUE_PTR_BITS + 1)'(1);
      end
    end
  end

  // pass-through requests are marked here; every request, averaging or not, is queued in the slots
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= '{sample: sample, first: first, pass: (k == '0)};
    end
  end

endmodule

// File: hw/rtl/smav_back.sv
module smav_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [smav_pkg::FILL_BITS-1:0] k,
  input  logic                          restart,
  input  logic                          item_valid,
  input  smav_pkg::item_t               item,
  output logic                          item_take,
  output logic                          empty,
  input  logic                          pop,
  output logic [smav_pkg::SAMPLE_BITS-1:0] average
);

  smav_pkg::state_t state;
  smav_pkg::state_t state_next;

  logic [smav_pkg::ADDR_BITS-1:0]   write_slot;
  logic [smav_pkg::FILL_BITS-1:0]   fill_count;
  logic [smav_pkg::SUM_BITS-1:0]    window_sum;
  logic [smav_pkg::SAMPLE_BITS-1:0] cur_sample;
  logic [smav_pkg::SAMPLE_BITS-1:0] pend;
  logic                             res_valid;

  logic                             ram_wr;
  logic                             div_start;
  logic                             res_load;
  logic [smav_pkg::ADDR_BITS-1:0]   oldest;
  logic [smav_pkg::SAMPLE_BITS-1:0] old_sample;
  logic                             win_full;
  logic [smav_pkg::FILL_BITS-1:0]   fill_next;
  logic [smav_pkg::SUM_BITS-1:0]    sum_base;
  logic [smav_pkg::SUM_BITS-1:0]    window_sum_next;
  logic                             div_busy;
  logic                             div_done;
  logic [smav_pkg::SUM_BITS-1:0]    quotient;

  assign oldest    = write_slot - k[smav_pkg::ADDR_BITS-1:0];
  assign win_full  = fill_count >= k;
  assign fill_next = win_full ? k : fill_count + smav_pkg::FILL_BITS'(1);
  assign sum_base  = win_full ? window_sum - smav_pkg::SUM_BITS'(old_sample) : window_sum;
  assign window_sum_next = sum_base + smav_pkg::SUM_BITS'(cur_sample);
  assign empty     = !res_valid;

  smav_ram #(
    .WIDTH (smav_pkg::SAMPLE_BITS),
    .DEPTH (smav_pkg::MAX_WINDOW)
  ) u_history (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (write_slot),
    .wr_data (cur_sample),
    .rd_en   (item_take),
    .rd_addr (oldest),
    .rd_data (old_sample)
  );

  smav_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum_next),
    .divisor  (k),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      smav_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = item.pass ? smav_pkg::S_OUT : smav_pkg::S_UPDATE;
        end
      end
      smav_pkg::S_UPDATE: begin
        state_next = (fill_next == k) ? smav_pkg::S_DIV : smav_pkg::S_IDLE;
      end
      smav_pkg::S_DIV: begin
        if (div_done) begin
          state_next = smav_pkg::S_OUT;
        end
      end
      smav_pkg::S_OUT: begin
        if (!res_valid || pop) begin
          state_next = smav_pkg::S_IDLE;
        end
      end
      default: state_next = smav_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_take = 1'b0;
    ram_wr    = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      smav_pkg::S_IDLE:   item_take = item_valid;
      smav_pkg::S_UPDATE: begin
        ram_wr    = 1'b1;
        div_start = fill_next == k;
      end
      smav_pkg::S_DIV:    ;
      smav_pkg::S_OUT:    res_load = !res_valid || pop;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= smav_pkg::S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      window_sum <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (restart || (item_take && item.first)) begin
        fill_count <= '0;
        window_sum <= '0;
      end else if (ram_wr) begin
        fill_count <= fill_next;
        window_sum <= window_sum_next;
      end
      if (ram_wr) begin
        write_slot <= write_slot + smav_pkg::ADDR_BITS'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cur_sample <= item.sample;
      pend       <= item.sample;
    end
    if (div_done) begin
      pend <= quotient[smav_pkg::SAMPLE_BITS-1:0];
    end
    if (res_load) begin
      average <= pend;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= smav_pkg::FILL_BITS'(smav_pkg::MAX_WINDOW))
    else $error("fill count above window capacity");

  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == smav_pkg::S_DIV && div_busy)
    else $error("divider not running after start");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == smav_pkg::S_OUT)
    else $error("result raised outside output step");

endmodule

// File: hw/rtl/simple_moving_average.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------
// input    | push / full          | sample[19:0], first
// result   | empty / pop          | average[19:0]
// config   | psel penable pwrite  | paddr[2:0], pwdata, prdata
//
// averaging request: taken in idle, then an update step; once the window is full, the bit-serial divider
// (one quotient bit per cycle over the 27-bit sum) runs before the output step
// pass-through request (window length 0): taken in idle, then straight to the output step
// reset: window length 4, queues empty; the ring has no clearing pass
// a 4-deep input queue takes requests while the back end works or the result waits on pop
module simple_moving_average (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [smav_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                              first,
  output logic                              empty,
  input  logic                              pop,
  output logic [smav_pkg::SAMPLE_BITS-1:0]  average,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smav_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [smav_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [smav_pkg::PDATA_BITS-1:0]   prdata,
  output logic                              pready
);

  logic [smav_pkg::WLEN_BITS-1:0] window_length;
  logic [smav_pkg::FILL_BITS-1:0] k;
  logic                           cfg_wr;
  logic                           item_valid;
  logic                           item_take;
  smav_pkg::item_t                item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && paddr[2] == smav_pkg::REG_WINDOW_LENGTH;
  assign prdata = (paddr[2] == smav_pkg::REG_WINDOW_LENGTH)
                  ? smav_pkg::PDATA_BITS'(window_length) : '0;

  // oversized window saturates
  assign k = (window_length > smav_pkg::WLEN_BITS'(smav_pkg::MAX_WINDOW))
             ? smav_pkg::FILL_BITS'(smav_pkg::MAX_WINDOW)
             : smav_pkg::FILL_BITS'(window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= smav_pkg::WINDOW_LENGTH_RESET;
    end else if (cfg_wr) begin
      window_length <= pwdata[smav_pkg::WLEN_BITS-1:0];
    end
  end

  smav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .first      (first),
    .k          (k),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  smav_back u_back (
    .clk        (clk),
    .rst        (rst),
    .k          (k),
    .restart    (cfg_wr),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .average    (average)
  );

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smav_pkg::*;

  localparam logic [PADDR_BITS-1:0] ADDR_WINDOW_LENGTH = PADDR_BITS'(4 * REG_WINDOW_LENGTH);
  localparam logic [PADDR_BITS-1:0] ADDR_UNMAPPED      = PADDR_BITS'(4);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX        = '1;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int RANDOM_TARGET   = 880;

  typedef enum int {RX_STREAM, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_pattern_t;

  logic                   clk;
  logic                   rst     = 1'b1;
  logic                   push    = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] sample  = '0;
  logic                   first   = 1'b0;
  logic                   empty;
  logic                   pop     = 1'b0;
  logic [SAMPLE_BITS-1:0] average;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_BITS-1:0]  paddr   = '0;
  logic [PDATA_BITS-1:0]  pwdata  = '0;
  logic [PDATA_BITS-1:0]  prdata;
  logic                   pready;

  // averaging predictor state
  logic [SAMPLE_BITS-1:0] ring_samples [MAX_WINDOW];
  logic [ADDR_BITS-1:0]   ring_slot;
  logic [FILL_BITS-1:0]   fill_cnt;
  logic [SUM_BITS-1:0]    run_sum;
  logic [WLEN_BITS-1:0]   win_len;

  logic [SAMPLE_BITS-1:0] expected_averages [$];

  int error_count;
  int samples_sent;
  int averages_checked;
  int settings_written;
  int full_cycles;
  int holdoff_request;
  int burst_left;
  int sender_gap_max;

  simple_moving_average u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .first   (first),
    .empty   (empty),
    .pop     (pop),
    .average (average),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 20) begin
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  function automatic bit predict_average(input logic [SAMPLE_BITS-1:0] s, input logic f,
                                         output logic [SAMPLE_BITS-1:0] avg);
    int k;
    int oldest;
    k = (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
    avg = '0;
    if (f) begin
      fill_cnt = '0;
      run_sum = '0;
    end
    if (k == 0) begin
      avg = s;
      return 1'b1;
    end
    if (fill_cnt >= k) begin
      oldest = (int'(ring_slot) + MAX_WINDOW - k) % MAX_WINDOW;
      run_sum = run_sum - SUM_BITS'(ring_samples[oldest]);
      fill_cnt = FILL_BITS'(k);
    end else begin
      fill_cnt = fill_cnt + 1'b1;
    end
    ring_samples[ring_slot] = s;
    run_sum = run_sum + SUM_BITS'(s);
    ring_slot = ring_slot + 1'b1;
    if (fill_cnt < k) return 1'b0;
    avg = SAMPLE_BITS'(run_sum / k);
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return SAMPLE_MAX;
    if (r < 5) return '0;
    if (r < 7) return SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 1023));
    return SAMPLE_BITS'($urandom());
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic f);
    logic [SAMPLE_BITS-1:0] avg;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    sample <= s;
    first <= f;
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    if (predict_average(s, f, avg)) expected_averages = {expected_averages, avg};
    samples_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [PADDR_BITS-1:0] addr,
                                input logic [PDATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_WINDOW_LENGTH) begin
      win_len = data[WLEN_BITS-1:0];
      fill_cnt = '0;
      run_sum = '0;
      settings_written++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_window_length();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_WINDOW_LENGTH;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== PDATA_BITS'(win_len)) begin
      report_mismatch("window_length read", prdata, PDATA_BITS'(win_len));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_window();
    read_window_length();
    send_sample(SAMPLE_MAX, 1'b1);
    repeat (3) send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_BITS'(1), 1'b0);
  endtask

  task automatic test_pass_through();
    settle();
    write_register(ADDR_WINDOW_LENGTH, '0);
    read_window_length();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_BITS'(20'hA5A5A), 1'b0);
  endtask

  task automatic test_sequence_restart();
    settle();
    write_register(ADDR_WINDOW_LENGTH, PDATA_BITS'(2));
    send_sample(SAMPLE_BITS'(20'h00400), 1'b0);
    send_sample(SAMPLE_BITS'(20'h00C00), 1'b0);
    send_sample(SAMPLE_BITS'(20'h12345), 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
  endtask

  task automatic test_unmapped_register();
    settle();
    write_register(ADDR_UNMAPPED, '0);
    send_sample(SAMPLE_BITS'(1), 1'b0);
    settle();
    read_window_length();
  endtask

  task automatic test_window_change();
    settle();
    write_register(ADDR_WINDOW_LENGTH, PDATA_BITS'(200));
    read_window_length();
    send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b0);
    settle();
    write_register(ADDR_WINDOW_LENGTH, PDATA_BITS'(3));
    repeat (3) send_sample(pick_sample(), 1'b0);
    settle();
    write_register(ADDR_WINDOW_LENGTH, PDATA_BITS'(1));
    send_sample(SAMPLE_MAX, 1'b0);
  endtask

  task automatic test_random_windows();
    int phase;
    int wl;
    int eff;
    int count;
    int r;
    phase = 0;
    while (samples_sent < RANDOM_TARGET) begin
      phase++;
      r = $urandom_range(0, 9);
      if (phase == 4) wl = MAX_WINDOW;
      else if (phase == 9) wl = $urandom_range(MAX_WINDOW + 1, 255);
      else if (r == 0) wl = 0;
      else if (r < 7) wl = $urandom_range(1, 8);
      else if (r < 9) wl = $urandom_range(9, 32);
      else wl = $urandom_range(33, MAX_WINDOW - 1);
      eff = (wl > MAX_WINDOW) ? MAX_WINDOW : wl;
      settle();
      if ($urandom_range(0, 3) == 0) write_register(ADDR_UNMAPPED, $urandom());
      write_register(ADDR_WINDOW_LENGTH,
                     {(PDATA_BITS - WLEN_BITS)'($urandom()), WLEN_BITS'(wl)});
      read_window_length();
      case ($urandom_range(0, 2))
        0: sender_gap_max = 0;
        1: sender_gap_max = 3;
        default: sender_gap_max = 8;
      endcase
      count = eff + $urandom_range(4, 40);
      repeat (count) send_sample(pick_sample(), $urandom_range(0, 24) == 0);
    end
  endtask

  task automatic test_backpressure();
    settle();
    write_register(ADDR_WINDOW_LENGTH, PDATA_BITS'(1));
    sender_gap_max = 0;
    holdoff_request = HOLDOFF_CYCLES;
    repeat (40) send_sample(pick_sample(), 1'b0);
    settle();
    sender_gap_max = 5;
    repeat (20) send_sample(pick_sample(), $urandom_range(0, 4) == 0);
  endtask

  // result side: pop pattern, hold-off and checking
  initial begin : result_side
    int holdoff_left;
    int mode_age;
    rx_pattern_t rx_mode;
    logic want;
    logic [SAMPLE_BITS-1:0] exp_avg;
    holdoff_left = 0;
    mode_age = 0;
    rx_mode = RX_STREAM;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("average with no request waiting", 32'(average), '0);
        end else begin
          exp_avg = expected_averages.pop_front();
          if (average !== exp_avg) report_mismatch("average", 32'(average), 32'(exp_avg));
          averages_checked++;
        end
      end
      if (holdoff_request > 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      mode_age++;
      if (mode_age >= 97) begin
        mode_age = 0;
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_STREAM:       want = 1'b1;
        RX_COIN:         want = 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: want = (mode_age % 4 == 0);
        default:         want = ($urandom_range(0, 9) != 0);
      endcase
      if (holdoff_left > 0) begin
        holdoff_left--;
        want = 1'b0;
      end
      pop <= want && !rst;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (psel && penable)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    error_count = 0;
    samples_sent = 0;
    averages_checked = 0;
    settings_written = 0;
    full_cycles = 0;
    holdoff_request = 0;
    burst_left = 0;
    sender_gap_max = 4;
    win_len = WINDOW_LENGTH_RESET;
    ring_slot = '0;
    fill_cnt = '0;
    run_sum = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_window();
    test_pass_through();
    test_sequence_restart();
    test_unmapped_register();
    test_window_change();
    test_random_windows();
    test_backpressure();
    push <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d samples, %0d averages compared, %0d window length writes",
             samples_sent, averages_checked, settings_written);
    $display("summary: windows 0 to 255 incl. restarts and pass-through, %0d full cycles",
             full_cycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
